>>> design/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants for the lamp dimmer
// event codes, ramp modes, register map, state and config structs
// ----------------------------------------------------------------------------
package sld_pkg;

  // event kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_PACE   = 2'd1,
    OP_SECOND = 2'd2,
    OP_BUTTON = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_FADE_IN  = 3'd1,
    MODE_FADE_OUT = 3'd2,
    MODE_ADJ_UP   = 3'd3,
    MODE_ADJ_DOWN = 3'd4
  } mode_t;

  // register map
  localparam logic [2:0] REG_VOLUME_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_HOLD_SECONDS     = 3'd1;
  localparam logic [2:0] REG_BAR_LEVEL_ONE    = 3'd2;
  localparam logic [2:0] REG_BAR_LEVEL_TWO    = 3'd3;
  localparam logic [2:0] REG_BAR_LEVEL_THREE  = 3'd4;
  localparam logic [2:0] REG_BAR_LEVEL_FOUR   = 3'd5;
  localparam logic [2:0] REG_BAR_LEVEL_FIVE   = 3'd6;
  localparam logic [2:0] REG_BAR_LEVEL_SIX    = 3'd7;

  localparam int BAR_COUNT = 6;

  localparam logic [11:0] RST_VOLUME_THRESHOLD = 12'd3000;
  localparam logic [7:0]  RST_HOLD_SECONDS     = 8'd30;
  localparam logic [11:0] RST_BAR_LEVEL_ONE    = 12'd700;
  localparam logic [11:0] RST_BAR_LEVEL_TWO    = 12'd600;
  localparam logic [11:0] RST_BAR_LEVEL_THREE  = 12'd500;
  localparam logic [11:0] RST_BAR_LEVEL_FOUR   = 12'd400;
  localparam logic [11:0] RST_BAR_LEVEL_FIVE   = 12'd300;
  localparam logic [11:0] RST_BAR_LEVEL_SIX    = 12'd200;

  // duty limits and steps
  localparam logic [15:0] DUTY_TOP        = 16'hFF00;
  localparam logic [15:0] DUTY_STEP       = 16'h00FF;
  localparam logic [15:0] DUTY_STEP_FINE  = 16'h007F;
  localparam logic [15:0] DUTY_FADE_FLOOR = 16'h01FF;
  localparam logic [15:0] DUTY_DEAD_BAND  = 16'h1FFF;
  localparam logic [15:0] TARGET_MAX      = 16'hFFFE;
  localparam logic [15:0] TARGET_MIN      = 16'h00FF;
  localparam logic [11:0] LIGHT_OFFSET    = 12'd196;
  localparam logic [6:0]  LIGHT_GAIN      = 7'd80;
  localparam logic [11:0] LIGHT_LOW       = 12'd200;
  localparam logic [11:0] LIGHT_HIGH      = 12'd1000;
  localparam logic [7:0]  HOLD_MAX        = 8'd255;

  typedef struct packed {
    logic [11:0]                volume_threshold;
    logic [7:0]                 hold_seconds;
    logic [BAR_COUNT-1:0][11:0] bar_level;
  } cfg_t;

  typedef struct packed {
    logic        system_on;
    logic        lamp_on;
    logic [7:0]  hold_count;
    logic [15:0] duty;
    logic [15:0] compare_value;
    logic [15:0] ramp_target;
    mode_t       ramp_mode;
    logic        pace_phase;
    logic [5:0]  bar_pattern;
    logic        enable_pin;
  } state_t;

  // per-sample values derived from the light reading
  typedef struct packed {
    logic [15:0] target;
    logic [5:0]  bar;
  } light_info_t;

endpackage

>>> design/sld_target.sv
// ----------------------------------------------------------------------------
// sld_target: light reading to target duty and bar pattern
// linear map with clamps, six threshold compares
// ----------------------------------------------------------------------------
module sld_target (
  input  logic [11:0]          light,
  input  sld_pkg::cfg_t        cfg,
  output sld_pkg::light_info_t info
);

  logic [11:0] light_rel;
  logic [18:0] scaled;

  assign light_rel = light - sld_pkg::LIGHT_OFFSET;
  assign scaled    = light_rel * sld_pkg::LIGHT_GAIN;

  always_comb begin
    if (light <= sld_pkg::LIGHT_LOW) begin
      info.target = sld_pkg::TARGET_MIN;
    end else if (light >= sld_pkg::LIGHT_HIGH) begin
      info.target = sld_pkg::TARGET_MAX;
    end else begin
      info.target = scaled[15:0];
    end
    for (int k = 0; k < sld_pkg::BAR_COUNT; k++) begin
      info.bar[k] = (light <= cfg.bar_level[k]);
    end
  end

endmodule

>>> design/sld_ctrl.sv
// ----------------------------------------------------------------------------
// sld_ctrl: lamp controller state and per-event update
// holds the state registers and computes the state after one event
// ----------------------------------------------------------------------------
module sld_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  sld_pkg::op_t         op,
  input  logic [11:0]          volume,
  input  sld_pkg::light_info_t info,
  input  sld_pkg::cfg_t        cfg,
  output sld_pkg::state_t      state,
  output sld_pkg::state_t      state_next
);

  function automatic sld_pkg::state_t ramp_check(input sld_pkg::state_t s_in);
    sld_pkg::state_t s;
    logic go;
    s  = s_in;
    go = 1'b0;
    case (s.ramp_mode)
      sld_pkg::MODE_FADE_IN:
        go = (s.duty < sld_pkg::DUTY_TOP) && s.system_on;
      sld_pkg::MODE_FADE_OUT:
        go = (s.duty >= sld_pkg::DUTY_FADE_FLOOR);
      sld_pkg::MODE_ADJ_UP:
        go = (s.duty <= s.ramp_target) && (s.duty < sld_pkg::DUTY_TOP) && s.system_on;
      sld_pkg::MODE_ADJ_DOWN:
        go = (s.duty >= s.ramp_target) && (s.duty >= sld_pkg::DUTY_STEP) && s.system_on;
      default: go = 1'b0;
    endcase
    if (go) begin
      s.compare_value = s.duty;
    end else begin
      if (s.ramp_mode == sld_pkg::MODE_FADE_OUT) begin
        s.enable_pin = 1'b0;
        s.lamp_on    = 1'b0;
        s.hold_count = '0;
      end
      s.ramp_mode = sld_pkg::MODE_IDLE;
    end
    return s;
  endfunction

  function automatic sld_pkg::state_t ramp_start(input sld_pkg::state_t s_in,
                                                 input sld_pkg::mode_t mode);
    sld_pkg::state_t s;
    s            = s_in;
    s.ramp_mode  = mode;
    s.pace_phase = 1'b0;
    return ramp_check(s);
  endfunction

  sld_pkg::state_t s;
  logic            fade_started;
  logic [15:0]     spread;

  always_comb begin
    s            = state;
    fade_started = 1'b0;
    spread       = '0;
    case (op)
      sld_pkg::OP_SAMPLE: begin
        if (s.system_on && (s.ramp_mode == sld_pkg::MODE_IDLE)) begin
          if (volume >= cfg.volume_threshold) begin
            if (!s.lamp_on) begin
              s.lamp_on    = 1'b1;
              s.hold_count = '0;
              s.enable_pin = 1'b1;
              s = ramp_start(s, sld_pkg::MODE_FADE_IN);
              fade_started = (s.ramp_mode != sld_pkg::MODE_IDLE);
            end else begin
              s.hold_count = '0;
            end
          end
          if (!fade_started) begin
            if (!s.lamp_on) begin
              s.bar_pattern = info.bar;
            end else begin
              s.ramp_target = info.target;
              if (s.duty < s.ramp_target) begin
                spread = s.ramp_target - s.duty;
                if (spread > sld_pkg::DUTY_DEAD_BAND) begin
                  s = ramp_start(s, sld_pkg::MODE_ADJ_UP);
                end
              end else begin
                spread = s.duty - s.ramp_target;
                if (spread > sld_pkg::DUTY_DEAD_BAND) begin
                  s = ramp_start(s, sld_pkg::MODE_ADJ_DOWN);
                end
              end
            end
          end
        end
      end
      sld_pkg::OP_PACE: begin
        case (s.ramp_mode)
          sld_pkg::MODE_FADE_IN, sld_pkg::MODE_ADJ_UP: begin
            s.duty = s.duty + sld_pkg::DUTY_STEP;
            s = ramp_check(s);
          end
          sld_pkg::MODE_FADE_OUT: begin
            // fade-out steps on every second pace tick
            s.pace_phase = !s.pace_phase;
            if (!s.pace_phase) begin
              s.duty = s.duty - sld_pkg::DUTY_STEP;
              s = ramp_check(s);
            end
          end
          sld_pkg::MODE_ADJ_DOWN: begin
            s.duty = s.duty - sld_pkg::DUTY_STEP_FINE;
            s = ramp_check(s);
          end
          default: s.ramp_mode = sld_pkg::MODE_IDLE;
        endcase
      end
      sld_pkg::OP_SECOND: begin
        if (s.lamp_on && (s.ramp_mode != sld_pkg::MODE_FADE_OUT)) begin
          if (s.hold_count < sld_pkg::HOLD_MAX) begin
            s.hold_count = s.hold_count + 8'd1;
          end
          if (s.hold_count >= cfg.hold_seconds) begin
            s = ramp_start(s, sld_pkg::MODE_FADE_OUT);
          end
        end
      end
      sld_pkg::OP_BUTTON: begin
        if (s.system_on) begin
          s.system_on   = 1'b0;
          s.bar_pattern = '0;
          s = ramp_start(s, sld_pkg::MODE_FADE_OUT);
        end else begin
          s.system_on  = 1'b1;
          s.lamp_on    = 1'b0;
          s.hold_count = '0;
        end
      end
      default: s = state;
    endcase
    state_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.system_on     <= 1'b0;
      state.lamp_on       <= 1'b0;
      state.hold_count    <= '0;
      state.duty          <= '0;
      state.compare_value <= '0;
      state.ramp_target   <= sld_pkg::TARGET_MAX;
      state.ramp_mode     <= sld_pkg::MODE_IDLE;
      state.pace_phase    <= 1'b0;
      state.bar_pattern   <= '0;
      state.enable_pin    <= 1'b0;
    end else if (update) begin
      state <= state_next;
    end
  end

endmodule

>>> design/sound_light_lamp_dimmer.sv
// ----------------------------------------------------------------------------
// sound_light_lamp_dimmer: sound-triggered, light-tracking lamp controller
// takes sample, pace tick, second tick and button events; one result per event
// ----------------------------------------------------------------------------
// path: a beat accepted on the slave side passes the input register, then the
//   result register, before its result reaches the master side
// throughput: one event per cycle while results drain; single-pass state update
// reset: rst synchronous, active high; clears the state, both stages and
//   loads the register defaults
// ----------------------------------------------------------------------------
module sound_light_lamp_dimmer (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] volume, [23:12] light
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] lamp_enable, [16:1] pwm_compare,
                                      // [22:17] bar_leds, [23] lamp_active,
                                      // [24] system_enabled, [25] ramp_busy,
                                      // [31:26] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  // configuration registers
  sld_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volume_threshold <= sld_pkg::RST_VOLUME_THRESHOLD;
      cfg.hold_seconds     <= sld_pkg::RST_HOLD_SECONDS;
      cfg.bar_level[0]     <= sld_pkg::RST_BAR_LEVEL_ONE;
      cfg.bar_level[1]     <= sld_pkg::RST_BAR_LEVEL_TWO;
      cfg.bar_level[2]     <= sld_pkg::RST_BAR_LEVEL_THREE;
      cfg.bar_level[3]     <= sld_pkg::RST_BAR_LEVEL_FOUR;
      cfg.bar_level[4]     <= sld_pkg::RST_BAR_LEVEL_FIVE;
      cfg.bar_level[5]     <= sld_pkg::RST_BAR_LEVEL_SIX;
    end else if (cfg_we) begin
      case (cfg_index)
        sld_pkg::REG_VOLUME_THRESHOLD: cfg.volume_threshold <= cfg_data;
        sld_pkg::REG_HOLD_SECONDS:     cfg.hold_seconds     <= cfg_data[7:0];
        sld_pkg::REG_BAR_LEVEL_ONE:    cfg.bar_level[0]     <= cfg_data;
        sld_pkg::REG_BAR_LEVEL_TWO:    cfg.bar_level[1]     <= cfg_data;
        sld_pkg::REG_BAR_LEVEL_THREE:  cfg.bar_level[2]     <= cfg_data;
        sld_pkg::REG_BAR_LEVEL_FOUR:   cfg.bar_level[3]     <= cfg_data;
        sld_pkg::REG_BAR_LEVEL_FIVE:   cfg.bar_level[4]     <= cfg_data;
        sld_pkg::REG_BAR_LEVEL_SIX:    cfg.bar_level[5]     <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  // input register stage
  logic         in_valid;
  sld_pkg::op_t in_op;
  logic [11:0]  in_volume;
  logic [11:0]  in_light;
  logic         advance;

  // the event moves on when the result register is empty or being drained
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op     <= sld_pkg::op_t'(s_axis_tuser);
      in_volume <= s_axis_tdata[11:0];
      in_light  <= s_axis_tdata[23:12];
    end
  end

  // light mapping and state update
  sld_pkg::light_info_t info;
  sld_pkg::state_t      state;
  sld_pkg::state_t      state_next;

  sld_target u_target (
    .light (in_light),
    .cfg   (cfg),
    .info  (info)
  );

  sld_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .op         (in_op),
    .volume     (in_volume),
    .info       (info),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next)
  );

  // result register: state after the event, packed for the master side
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {6'd0,
                       (state_next.ramp_mode != sld_pkg::MODE_IDLE),
                       state_next.system_on,
                       state_next.lamp_on,
                       state_next.bar_pattern,
                       state_next.compare_value,
                       state_next.enable_pin};
    end
  end

  // every event that moves on leaves a result waiting
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("event advanced without producing a result");

  // a lit lamp always has its driver enabled
  a_lamp_enabled: assert property (@(posedge clk) disable iff (rst)
    state.lamp_on |-> state.enable_pin)
    else $error("lamp marked lit with driver disabled");

  // only a fade-out may run while the system is off
  a_ramp_needs_on: assert property (@(posedge clk) disable iff (rst)
    (state.ramp_mode != sld_pkg::MODE_IDLE && state.ramp_mode != sld_pkg::MODE_FADE_OUT)
      |-> state.system_on)
    else $error("fade-in or adjust ramp running with system off");

  // bar stays dark once the system has been switched off by the button
  a_bar_dark_off: assert property (@(posedge clk) disable iff (rst)
    (advance && in_op == sld_pkg::OP_BUTTON && state.system_on)
      |=> (state.bar_pattern == 6'd0))
    else $error("bar not cleared on switch-off");

endmodule

>>> bench/lamp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamp_result_checker: scoreboard for the sound and light lamp dimmer
// watches the event, result and register-write ports, keeps its own copy of
// the controller state and register values, and checks every result beat
// ----------------------------------------------------------------------------
module lamp_result_checker
  import sld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_valid,
  input  logic        s_ready,
  input  logic [23:0] s_data,
  input  logic [1:0]  s_user,
  input  logic        m_valid,
  input  logic        m_ready,
  input  logic [31:0] m_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          outstanding,
  output int          mismatches,
  output int          compared
);

  localparam logic [15:0] FULL_DUTY   = 16'hFF00;
  localparam logic [15:0] COARSE_STEP = 16'h00FF;
  localparam logic [15:0] FINE_STEP   = 16'h007F;
  localparam logic [15:0] FADE_FLOOR  = 16'h01FF;
  localparam logic [15:0] DEAD_ZONE   = 16'h1FFF;
  localparam logic [15:0] GOAL_BRIGHT = 16'hFFFE;
  localparam logic [15:0] GOAL_DIM    = 16'h00FF;
  localparam int          DARK_LIGHT  = 200;
  localparam int          BRIGHT_LIGHT = 1000;
  localparam int          LIGHT_BASE  = 196;
  localparam int          LIGHT_SCALE = 80;
  localparam logic [7:0]  HOLD_CAP    = 8'd255;

  // register copy
  logic [11:0] thr_c;
  logic [7:0]  hold_c;
  logic [11:0] lvl_c [6];

  // controller state copy
  logic        sys_on_m, lit_m, en_m, phase_m;
  logic [7:0]  hold_m;
  logic [15:0] duty_m, cmp_m, goal_m;
  mode_t       mode_m;
  logic [5:0]  bar_m;

  logic [31:0] expected_states [$];
  int          errs;
  int          n_cmp;

  function void restore_defaults();
    thr_c    = 12'd3000;
    hold_c   = 8'd30;
    lvl_c    = '{12'd700, 12'd600, 12'd500, 12'd400, 12'd300, 12'd200};
    sys_on_m = 1'b0;
    lit_m    = 1'b0;
    en_m     = 1'b0;
    phase_m  = 1'b0;
    hold_m   = '0;
    duty_m   = '0;
    cmp_m    = '0;
    goal_m   = GOAL_BRIGHT;
    mode_m   = MODE_IDLE;
    bar_m    = '0;
  endfunction

  function void store_setting(logic [2:0] idx, logic [11:0] val);
    case (idx)
      REG_VOLUME_THRESHOLD: thr_c = val;
      REG_HOLD_SECONDS:     hold_c = val[7:0];
      default:              lvl_c[idx - REG_BAR_LEVEL_ONE] = val;
    endcase
  endfunction

  // decide whether the running ramp keeps going at the current duty
  function void ramp_settle();
    logic go;
    go = 1'b0;
    case (mode_m)
      MODE_FADE_IN:  go = duty_m < FULL_DUTY && sys_on_m;
      MODE_FADE_OUT: go = duty_m >= FADE_FLOOR;
      MODE_ADJ_UP:   go = duty_m <= goal_m && duty_m < FULL_DUTY && sys_on_m;
      MODE_ADJ_DOWN: go = duty_m >= goal_m && duty_m >= GOAL_DIM && sys_on_m;
      default: begin
        mode_m = MODE_IDLE;
        return;
      end
    endcase
    if (go) begin
      cmp_m = duty_m;
      return;
    end
    if (mode_m == MODE_FADE_OUT) begin
      en_m   = 1'b0;
      lit_m  = 1'b0;
      hold_m = '0;
    end
    mode_m = MODE_IDLE;
  endfunction

  function void ramp_begin(mode_t m);
    mode_m  = m;
    phase_m = 1'b0;
    ramp_settle();
  endfunction

  function void ramp_pace();
    case (mode_m)
      MODE_FADE_IN, MODE_ADJ_UP: duty_m = duty_m + COARSE_STEP;
      MODE_FADE_OUT: begin
        // fade-out moves on every other pace tick
        phase_m = ~phase_m;
        if (phase_m)
          return;
        duty_m = duty_m - COARSE_STEP;
      end
      MODE_ADJ_DOWN: duty_m = duty_m - FINE_STEP;
      default: return;
    endcase
    ramp_settle();
  endfunction

  function void track_light(logic [11:0] lt);
    if (int'(lt) <= DARK_LIGHT)
      goal_m = GOAL_DIM;
    else if (int'(lt) >= BRIGHT_LIGHT)
      goal_m = GOAL_BRIGHT;
    else
      goal_m = 16'((int'(lt) - LIGHT_BASE) * LIGHT_SCALE);
    if (duty_m < goal_m) begin
      if (goal_m - duty_m > DEAD_ZONE)
        ramp_begin(MODE_ADJ_UP);
    end else if (duty_m - goal_m > DEAD_ZONE) begin
      ramp_begin(MODE_ADJ_DOWN);
    end
  endfunction

  function void take_sample(logic [11:0] vol, logic [11:0] lt);
    logic       fresh;
    logic [5:0] pat;
    if (!sys_on_m || mode_m != MODE_IDLE)
      return;
    if (vol >= thr_c) begin
      fresh  = !lit_m;
      lit_m  = 1'b1;
      hold_m = '0;
      if (fresh) begin
        en_m = 1'b1;
        ramp_begin(MODE_FADE_IN);
        if (mode_m != MODE_IDLE)
          return;
      end
    end
    if (!lit_m) begin
      pat = '0;
      for (int k = 0; k < 6; k++)
        if (lt <= lvl_c[k])
          pat[k] = 1'b1;
      bar_m = pat;
    end else begin
      track_light(lt);
    end
  endfunction

  function logic [31:0] predict_outputs(op_t op, logic [11:0] vol, logic [11:0] lt);
    case (op)
      OP_SAMPLE: take_sample(vol, lt);
      OP_PACE:   ramp_pace();
      OP_SECOND: begin
        if (lit_m && mode_m != MODE_FADE_OUT) begin
          if (hold_m < HOLD_CAP)
            hold_m = hold_m + 8'd1;
          if (hold_m >= hold_c)
            ramp_begin(MODE_FADE_OUT);
        end
      end
      OP_BUTTON: begin
        if (sys_on_m) begin
          sys_on_m = 1'b0;
          bar_m    = '0;
          ramp_begin(MODE_FADE_OUT);
        end else begin
          sys_on_m = 1'b1;
          lit_m    = 1'b0;
          hold_m   = '0;
        end
      end
      default: ;
    endcase
    return {6'd0, mode_m != MODE_IDLE, sys_on_m, lit_m, bar_m, cmp_m, en_m};
  endfunction

  task check_field(string what, logic [15:0] want, logic [15:0] seen);
    if (want !== seen) begin
      errs++;
      if (errs <= 10)
        $display("result %0d: %s expected %0h got %0h", n_cmp, what, want, seen);
    end
  endtask

  task compare_result(logic [31:0] want, logic [31:0] seen);
    check_field("lamp_enable", 16'(want[0]), 16'(seen[0]));
    check_field("pwm_compare", want[16:1], seen[16:1]);
    check_field("bar_leds", 16'(want[22:17]), 16'(seen[22:17]));
    check_field("lamp_active", 16'(want[23]), 16'(seen[23]));
    check_field("system_enabled", 16'(want[24]), 16'(seen[24]));
    check_field("ramp_busy", 16'(want[25]), 16'(seen[25]));
    check_field("pad bits", 16'(want[31:26]), 16'(seen[31:26]));
  endtask

  always @(posedge clk) begin : watch
    logic [31:0] want;
    if (rst) begin
      restore_defaults();
      expected_states.delete();
    end else begin
      // results first, so a beat never meets an expectation pushed this edge
      if (m_valid && m_ready) begin
        if (expected_states.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("result beat %0h arrived with nothing expected", m_data);
        end else begin
          want = expected_states.pop_front();
          compare_result(want, m_data);
          n_cmp++;
        end
      end
      if (cfg_we)
        store_setting(cfg_index, cfg_data);
      if (s_valid && s_ready)
        expected_states.push_back(predict_outputs(op_t'(s_user), s_data[11:0],
                                                  s_data[23:12]));
    end
    outstanding <= expected_states.size();
    mismatches  <= errs;
    compared    <= n_cmp;
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: event stimulus for the sound and light lamp dimmer
// drives sample, pace, second and button beats in bursts against a stalling
// result sink, over four register settings; a separate checker predicts and
// compares every result beat, this module only drives and gives the verdict
// ----------------------------------------------------------------------------
module tb
  import sld_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] s_data = '0;     // [11:0] volume, [23:12] light
  logic [1:0]  s_user = '0;     // [1:0] operation
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;          // [0] lamp_enable, [16:1] pwm_compare,
                                // [22:17] bar_leds, [23] lamp_active,
                                // [24] system_enabled, [25] ramp_busy
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  int outstanding, mismatches, compared;

  // stimulus bookkeeping
  int          burst_left = 0;
  int          total_sent = 0;
  int          op_count [4] = '{0, 0, 0, 0};
  bit          sys_on = 1'b0;       // the button always toggles the system
  logic [11:0] thr_now = 12'd3000;  // current volume threshold, for loud samples
  int          fails;
  int          phase_start;
  int          ep;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sound_light_lamp_dimmer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lamp_result_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .s_user      (s_user),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches),
    .compared    (compared)
  );

  // result sink: free-running, coin-flip and mostly-stalled stretches, picked at random
  int stall_left = 0;
  int stall_style = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_left  <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       m_ready <= 1'b1;
      1:       m_ready <= 1'($urandom_range(0, 1));
      default: m_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one event beat; bursts of random length with random gaps between them
  task automatic send_event(op_t op, logic [11:0] vol, logic [11:0] lt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {lt, vol};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    burst_left--;
    total_sent++;
    op_count[op]++;
    if (op == OP_BUTTON)
      sys_on = !sys_on;
  endtask

  // ticks and presses carry don't-care data, so it is randomized
  task automatic send_op(op_t op);
    send_event(op, 12'($urandom), 12'($urandom));
  endtask

  // light readings clustered around the clamp limits and the bar levels
  function automatic logic [11:0] pick_light();
    case ($urandom_range(0, 3))
      0:       return 12'($urandom_range(0, 260));
      1, 2:    return 12'($urandom_range(150, 1050));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic fire_sample(bit loud);
    logic [11:0] vol;
    if (loud)
      vol = 12'($urandom_range(thr_now, 4095));
    else if (thr_now == 0)
      vol = '0;  // every volume triggers at this threshold
    else
      vol = 12'($urandom_range(0, thr_now - 1));
    send_event(OP_SAMPLE, vol, pick_light());
  endtask

  task automatic power_up();
    if (!sys_on)
      send_op(OP_BUTTON);
  endtask

  // stop sending and wait for every expected result, then let the pipe drain
  task automatic settle_results(int limit);
    int waited;
    waited = 0;
    s_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(int ph);
    logic [11:0] th;
    logic [7:0]  hs;
    logic [11:0] lv [6];
    case (ph)
      1: begin
        // every sample triggers, hold expires on the first second tick
        th = 12'd0;
        hs = 8'd1;
        lv = '{12'd4095, 12'd4095, 12'd2048, 12'd0, 12'd1, 12'd0};
      end
      2: begin
        th = 12'd4095;
        hs = 8'd255;
        lv = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095};
      end
      default: begin
        th = 12'($urandom_range(500, 4095));
        hs = 8'($urandom_range(1, 6));
        for (int k = 0; k < 6; k++)
          lv[k] = 12'($urandom_range(0, 1100));
      end
    endcase
    write_reg(REG_VOLUME_THRESHOLD, th);
    // junk in the unused upper bits of the hold register
    write_reg(REG_HOLD_SECONDS, {4'($urandom_range(0, 15)), hs});
    for (int k = 0; k < 6; k++)
      write_reg(REG_BAR_LEVEL_ONE + 3'(k), lv[k]);
    cfg_we <= 1'b0;
    @(posedge clk);
    thr_now = th;
  endtask

  // full fade-in, a few light-tracking adjustments, then hold and fade-out
  task automatic deep_cycle();
    power_up();
    fire_sample(1'b1);
    repeat (256 + $urandom_range(0, 3)) begin
      if ($urandom_range(0, 15) == 0)
        fire_sample(1'($urandom_range(0, 1)));
      send_op(OP_PACE);
    end
    repeat ($urandom_range(3, 5)) begin
      fire_sample($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 40)) send_op(OP_PACE);
    end
    repeat ($urandom_range(1, 8)) begin
      send_op(OP_SECOND);
      repeat ($urandom_range(0, 6)) send_op(OP_PACE);
    end
    if ($urandom_range(0, 1))
      send_op(OP_BUTTON);
    repeat ($urandom_range(0, 80)) send_op(OP_PACE);
  endtask

  // trigger, partial fade-in with mixed events, maybe switch off mid-ramp
  task automatic short_cycle();
    power_up();
    fire_sample(1'b1);
    repeat ($urandom_range(1, 40)) begin
      case ($urandom_range(0, 9))
        0, 1:    fire_sample($urandom_range(0, 3) == 0);
        2:       send_op(OP_SECOND);
        default: send_op(OP_PACE);
      endcase
    end
    if ($urandom_range(0, 1))
      send_op(OP_BUTTON);
    repeat ($urandom_range(0, 20)) send_op(OP_PACE);
  endtask

  // off and on again clears the lit state, then quiet samples drive the bar
  task automatic bar_walk();
    if (sys_on) begin
      send_op(OP_BUTTON);
      repeat ($urandom_range(0, 12)) send_op(OP_PACE);
    end
    send_op(OP_BUTTON);
    repeat ($urandom_range(4, 15)) begin
      fire_sample(1'b0);
      if ($urandom_range(0, 3) == 0)
        send_op(OP_PACE);
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(5, 20))
      send_event(op_t'($urandom_range(0, 3)), 12'($urandom), 12'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset register values
    send_event(OP_SAMPLE, 12'd4095, 12'd0);     // system off: ignored
    send_op(OP_PACE);                           // no ramp running
    send_op(OP_SECOND);                         // lamp not lit
    send_op(OP_BUTTON);                         // switch on
    send_event(OP_SAMPLE, 12'd0, 12'd0);        // darkest: whole bar lit
    send_event(OP_SAMPLE, 12'd0, 12'd4095);     // brightest: bar dark
    send_event(OP_SAMPLE, 12'd2999, 12'd450);   // just below threshold, partial bar
    send_event(OP_SAMPLE, 12'd3000, 12'd4095);  // at threshold: fade-in, no adjust
    send_event(OP_SAMPLE, 12'd4095, 12'd0);     // ramp running: ignored
    send_op(OP_SECOND);                         // hold count moves while lit
    repeat (6) send_op(OP_PACE);
    send_op(OP_BUTTON);                         // off: fade-out replaces fade-in
    send_op(OP_SECOND);                         // ignored during fade-out
    send_op(OP_BUTTON);                         // on again, fade-out keeps going
    send_event(OP_SAMPLE, 12'd4095, 12'd4095);  // still ramping: ignored
    repeat (8) send_op(OP_PACE);                // fade-out runs out

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        // registers change only with nothing in flight
        settle_results(20000);
        apply_settings(ph);
      end
      phase_start = total_sent;
      ep = 0;
      while (total_sent - phase_start < 140) begin
        if (ep == 0 && ph == 3)
          deep_cycle();
        else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: short_cycle();
            4, 5, 6:    bar_walk();
            default:    noise_burst();
          endcase
        end
        ep++;
      end
    end

    settle_results(20000);
    fails = mismatches + outstanding;
    $display("covered %0d events: %0d samples, %0d pace ticks, %0d second ticks, %0d presses",
             total_sent, op_count[OP_SAMPLE], op_count[OP_PACE], op_count[OP_SECOND],
             op_count[OP_BUTTON]);
    $display("%0d results compared over four register settings, %0d failures",
             compared, fails);
    if (fails == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
